### src/ist_pkg.sv
// package: shared types and codes for the interval statistics table
package ist_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned ValW   = 64;
  localparam int unsigned StampW = 63;

  // samples are q16.16 and kept in that format without scaling
  localparam int unsigned FractionBits = 16;

  localparam logic [1:0] ModeStart  = 2'd0;
  localparam logic [1:0] ModeEnd    = 2'd1;
  localparam logic [1:0] ModeSample = 2'd2;

  localparam logic [1:0] StUpdated  = 2'd0;
  localparam logic [1:0] StCreated  = 2'd1;
  localparam logic [1:0] StNoStart  = 2'd2;
  localparam logic [1:0] StNegative = 2'd3;

  localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

  // one slot's contents as held in memory
  typedef struct packed {
    logic [StampW-1:0]      stamp;
    logic [CountW-1:0]      count;
    logic signed [ValW-1:0] last;
    logic signed [ValW-1:0] min;
    logic signed [ValW-1:0] max;
    logic signed [ValW-1:0] total;
  } slot_t;

  // request to the divider
  typedef struct packed {
    logic                   start;
    logic signed [ValW-1:0] dividend;
    logic [CountW-1:0]      divisor;
  } div_req_t;

endpackage

### src/ist_div.sv
// iterative signed-by-unsigned divider, one quotient bit per cycle, truncating
module ist_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ist_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic signed [63:0]          quot_o
);
  import ist_pkg::*;

  logic [ValW-1:0]   rem_q, rem_d, num_q, num_d;
  logic [CountW-1:0] den_q, den_d;
  logic              neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [6:0]        cnt_q, cnt_d;
  logic [ValW:0]     trial;
  logic [ValW-1:0]   shifted;
  logic [ValW-1:0]   mag;

  always_comb begin
    mag = req_i.dividend[ValW-1] ? (~req_i.dividend + 64'd1) : req_i.dividend;
    shifted = {rem_q[ValW-2:0], num_q[ValW-1]};
    trial = {1'b0, shifted} - {{(ValW-CountW+1){1'b0}}, den_q};
    rem_d = rem_q; num_d = num_q; den_d = den_q; neg_d = neg_q;
    busy_d = busy_q; cnt_d = cnt_q; done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0; num_d = mag; den_d = req_i.divisor;
      neg_d = req_i.dividend[ValW-1]; busy_d = 1'b1; cnt_d = 7'd0;
    end else if (busy_q) begin
      // shift in next dividend bit, quotient collects in num
      if (!trial[ValW]) begin
        rem_d = trial[ValW-1:0];
        num_d = {num_q[ValW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        num_d = {num_q[ValW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; num_q <= num_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? $signed(~num_q + 64'd1) : $signed(num_q);
endmodule

### src/interval_statistics_table_top.sv
// top level: slot memory, read-modify-write sequencer and result register
//
//  channel | dir | tuser     | tdata fields (low bit first)
//  s_axis  | in  | mode[1:0] | slot[5:0] timestamp_ns[68:6] sample_value[100:69]
//  m_axis  | out | -         | status[1:0] event_count[33:2] last[97:34] min[161:98]
//          |     |           | max[225:162] total[289:226] average[353:290]
//
// one request at a time: a read state, an update and write-back state, the
// 64 divider steps and done, then the result register; the divider sets the
// pace, and no new request is taken until the result is registered.
// valid bits reset at once; the slot memory needs no clearing pass.
// a held result stalls the sequencer only at the result register stage.
module interval_statistics_table_top #(
  parameter int unsigned SLOTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode
  input  logic [1:0]   s_axis_tuser,
  // slot, timestamp_ns, sample_value
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, event_count, last_value, min_value, max_value, total_value, average_value
  output logic [359:0] m_axis_tdata
);
  import ist_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [2:0] SIdle = 3'd0, SRead = 3'd1, SMod = 3'd2, SDiv = 3'd3,
                         SOut = 3'd4;

  slot_t          mem [SLOTS];
  logic [SLOTS-1:0] vld_q;
  logic [2:0]     st_q;
  logic [1:0]     mode_q, status_q;
  logic [AW-1:0]  addr_q;
  logic [StampW-1:0] ts_q;
  logic signed [ValW-1:0] samp_q;
  slot_t          rd_q, nw_q, nw_d;
  logic           nvld_q, nvld_d;
  logic [1:0]     status_d;
  logic           wr_d;
  logic [359:0]   out_q;
  logic           ovld_q;
  logic           out_load;
  div_req_t       dreq;
  logic           ddone;
  logic signed [ValW-1:0] dquot;
  logic [AW-1:0]  slot_map [64];
  logic [AW-1:0]  slot_idx;
  logic signed [ValW-1:0] v, sum;
  slot_t          base;

  // slot index folded into the table as a constant lookup
  for (genvar g = 0; g < 64; g++) begin : g_slot_map
    assign slot_map[g] = AW'(g % SLOTS);
  end

  assign slot_idx = slot_map[s_axis_tdata[5:0]];
  assign s_axis_tready = (st_q == SIdle);
  assign out_load = (st_q == SOut) && (!ovld_q || m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && s_axis_tvalid) begin
      mode_q <= s_axis_tuser;
      addr_q <= slot_idx;
      ts_q   <= s_axis_tdata[68:6];
      samp_q <= ValW'($signed(s_axis_tdata[100:69]));
    end
    if (st_q == SRead) rd_q <= mem[addr_q];
    if (wr_d) mem[addr_q] <= nw_d;
    if (st_q == SMod) begin
      nw_q <= nw_d; nvld_q <= nvld_d; status_q <= status_d;
    end
    if (out_load)
      out_q <= {6'd0, (nw_q.count == '0 || !nvld_q) ? 64'd0 : dquot, nw_q.total,
                nw_q.max, nw_q.min, nw_q.last, nw_q.count, status_q}
               & {360{nvld_q}} | {358'd0, status_q};
  end

  always_comb begin
    base = '{stamp: '0, count: '0, last: '0, min: ValMax, max: ValMin, total: '0};
    nw_d = rd_q; nvld_d = vld_q[addr_q]; status_d = StUpdated; wr_d = 1'b0;
    v = '0; sum = '0;
    if (st_q == SMod) begin
      case (mode_q)
        ModeStart: begin
          wr_d = 1'b1; nvld_d = 1'b1;
          if (!vld_q[addr_q]) begin
            nw_d = base; status_d = StCreated;
          end
          nw_d.stamp = ts_q;
        end
        ModeEnd, ModeSample: begin
          if (mode_q == ModeEnd) v = $signed({1'b0, ts_q - rd_q.stamp});
          else v = samp_q;
          if (!vld_q[addr_q]) begin
            if (mode_q == ModeEnd) begin
              status_d = StNoStart;
            end else begin
              nw_d = base; nw_d.last = samp_q; nvld_d = 1'b1;
              status_d = StCreated; wr_d = 1'b1;
            end
          end else if (mode_q == ModeEnd && rd_q.stamp > ts_q) begin
            status_d = StNegative;
          end else begin
            wr_d = 1'b1;
            nw_d.last = v;
            if (rd_q.count != '1) nw_d.count = rd_q.count + 32'd1;
            if (v > rd_q.max) nw_d.max = v;
            if (v < rd_q.min) nw_d.min = v;
            sum = rd_q.total + v;
            if (!v[63] && !rd_q.total[63] && sum[63]) nw_d.total = ValMax;
            else if (v[63] && rd_q.total[63] && !sum[63]) nw_d.total = ValMin;
            else nw_d.total = sum;
          end
        end
        default: ;
      endcase
    end
  end

  assign dreq = '{start: (st_q == SMod), dividend: nw_d.total, divisor: nw_d.count};

  ist_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; vld_q <= '0; ovld_q <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) ovld_q <= 1'b0;
      case (st_q)
        SIdle: if (s_axis_tvalid) st_q <= SRead;
        SRead: st_q <= SMod;
        SMod: begin
          vld_q[addr_q] <= nvld_d;
          st_q <= SDiv;
        end
        SDiv: if (ddone) st_q <= SOut;
        SOut: begin
          // waits here while the previous result is still held
          if (out_load) begin
            ovld_q <= 1'b1; st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;
endmodule
